// ===== src/aabb_body_physics_step_defines.svh =====
// Assertion macros used by the checker file of the rectangle body block.
`ifndef AABB_BODY_PHYSICS_STEP_DEFINES_SVH
`define AABB_BODY_PHYSICS_STEP_DEFINES_SVH

// Clocked check that is switched off while reset is held.
`define ABPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked check that stays live through reset.
`define ABPS_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/abps_pkg.sv =====
// Shared types and constants of the rectangle body physics block.
package abps_pkg;

    // Stream and register port widths.
    localparam int IN_W   = 104;
    localparam int OUT_W  = 104;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register indexes, selected by address bit 2.
    localparam logic REG_STATIC   = 1'b0;
    localparam logic REG_COLLIDES = 1'b1;

    // Serial multiplier operand widths.
    localparam int MUL_A_W   = 32;
    localparam int MUL_B_W   = 20;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W + 1;
    localparam int MUL_CNT_W = $clog2(MUL_B_W);

    // Physics constants in fixed point.
    localparam logic [MUL_B_W-1:0] STEP_SCALE    = 20'd10;
    localparam logic [MUL_A_W-1:0] GRAVITY_Q16   = 32'd642908;
    localparam logic [MUL_B_W-1:0] FRICTION_Q16  = 20'd62259;
    localparam logic [31:0]        DEAD_ZONE_Q16 = 32'd6554;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_OBST  = 2'd1,
        KIND_FORCE = 2'd2,
        KIND_PLACE = 2'd3
    } t_kind;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] mcand;
        logic [MUL_B_W-1:0] mplier;
    } t_mul_req;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } t_mul_rsp;

endpackage

// ===== src/abps_mul_ser.sv =====
// Serial-parallel multiplier: one multiplier bit per cycle, unsigned operands.
module abps_mul_ser
    import abps_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [MUL_CNT_W-1:0] r_cnt;
    logic [MUL_A_W-1:0]   r_mcand;
    logic [MUL_P_W-1:0]   r_prod;

    logic [MUL_A_W+1:0]   n_sum;
    logic [MUL_P_W-1:0]   n_prod;

    // The upper part of the product gains the multiplicand when the bit shifted
    // out at the bottom is set, and the whole word moves right by one.
    always_comb begin
        n_sum = {1'b0, r_prod[MUL_P_W-1:MUL_B_W]};
        if (r_prod[0]) begin
            n_sum = n_sum + {2'b0, r_mcand};
        end
        n_prod = {n_sum, r_prod[MUL_B_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= MUL_CNT_W'(MUL_B_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_prod  <= {{(MUL_A_W + 1){1'b0}}, i_req.mplier};
        end else if (r_busy) begin
            r_prod <= n_prod;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_prod;

endmodule

// ===== src/aabb_body_physics_step.sv =====
// Top level of the rectangle body block: integration, push-out and result register.
//
// Channel  Dir  Handshake                       Beat contents
// s_axis   in   s_axis_tvalid / s_axis_tready   one item: kind in tuser, operands in tdata
// m_axis   out  m_axis_tvalid / m_axis_tready   body state after the item
// apb      in   psel, penable, pwrite, pready   body_static at 0x0, body_collides at 0x4
//
// A tick runs four products through the bit-serial multiplier, 20 steps each; an
// obstacle that is tested passes S_OBS1 to S_OBS4 before S_FIN, while a skipped
// obstacle, a static tick, a force or a place goes from S_IDLE straight to S_FIN.
// One item is worked on at a time; the next beat is taken once its result sits in
// the output register, which holds it while m_axis_tready is low.
// Synchronous active-low reset clears the body to zero, body_collides to one.
module aabb_body_physics_step
    import abps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] step_time, [47:16] coord_x, [79:48] coord_y,
    // [91:80] extent_w, [103:92] extent_h
    input  logic [IN_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]        s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [15:0] pos_x, [31:16] pos_y, [63:32] speed_x, [95:64] speed_y,
    // [96] on_ground, [103:97] zero
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_OBS1 = 7'b0000100,
        S_OBS2 = 7'b0001000,
        S_OBS3 = 7'b0010000,
        S_OBS4 = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    typedef enum logic [1:0] {
        PH_GRAV   = 2'd0,
        PH_MOVE_X = 2'd1,
        PH_MOVE_Y = 2'd2,
        PH_FRIC   = 2'd3
    } t_phase;

    function automatic logic signed [15:0] f_sat16(input logic signed [33:0] v);
        logic signed [15:0] s;
        if (v > 34'sd32767) begin
            s = 16'sh7FFF;
        end else if (v < -34'sd32768) begin
            s = 16'sh8000;
        end else begin
            s = v[15:0];
        end
        return s;
    endfunction

    function automatic logic signed [31:0] f_sat32(input logic signed [33:0] v);
        logic signed [31:0] s;
        if (v > 34'sd2147483647) begin
            s = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            s = 32'sh8000_0000;
        end else begin
            s = v[31:0];
        end
        return s;
    endfunction

    function automatic logic [31:0] f_abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // Control and configuration.
    t_state   r_state, n_state;
    t_phase   r_phase, n_phase;
    t_mul_req r_mreq, n_mreq;
    t_mul_rsp mul_rsp;
    logic     r_static, n_static;
    logic     r_collides, n_collides;
    logic     r_mvalid, n_mvalid;

    // Body state.
    logic signed [15:0] r_left, n_left;
    logic signed [15:0] r_top, n_top;
    logic [11:0]        r_bw, n_bw;
    logic [11:0]        r_bh, n_bh;
    logic signed [31:0] r_vh, n_vh;
    logic signed [31:0] r_vv, n_vv;
    logic               r_grounded, n_grounded;

    // Work registers of the item in flight.
    logic [MUL_B_W-1:0] r_d, n_d;
    logic               r_neg, n_neg;
    logic signed [31:0] r_ox, n_ox;
    logic signed [31:0] r_oy, n_oy;
    logic [11:0]        r_ow, n_ow;
    logic [11:0]        r_oh, n_oh;
    logic signed [33:0] r_oxe, n_oxe;
    logic signed [33:0] r_oye, n_oye;
    logic signed [33:0] r_hix, n_hix;
    logic signed [33:0] r_hiy, n_hiy;
    logic signed [33:0] r_lox, n_lox;
    logic signed [33:0] r_loy, n_loy;
    logic signed [33:0] r_ovx, n_ovx;
    logic signed [33:0] r_ovy, n_ovy;
    logic [OUT_W-1:0]   r_mdata, n_mdata;

    // Input fields.
    t_kind              in_kind;
    logic [15:0]        in_step;
    logic signed [31:0] in_cx;
    logic signed [31:0] in_cy;
    logic [11:0]        in_ew;
    logic [11:0]        in_eh;
    logic [MUL_B_W-1:0] in_d;

    // Datapath helpers.
    logic signed [31:0] vv_grav;
    logic [20:0]        mv_mag;
    logic signed [21:0] mv_delta;
    logic signed [15:0] mv_base;
    logic signed [15:0] mv_edge;
    logic [31:0]        fr_mag;
    logic signed [31:0] fr_val;
    logic signed [33:0] bxe;
    logic signed [33:0] bye;
    logic               obs_skip;
    logic               obs_hit;
    logic               cfg_wr;

    assign in_kind = t_kind'(s_axis_tuser);
    assign in_step = s_axis_tdata[15:0];
    assign in_cx   = $signed(s_axis_tdata[47:16]);
    assign in_cy   = $signed(s_axis_tdata[79:48]);
    assign in_ew   = s_axis_tdata[91:80];
    assign in_eh   = s_axis_tdata[103:92];
    assign in_d    = {4'b0, in_step} * STEP_SCALE;

    // The gravity product stays below 2^39, so the product bits above bit 38 are zero.
    assign vv_grav  = f_sat32(34'(r_vv) + $signed({11'b0, mul_rsp.prod[38:16]}));
    assign mv_mag   = mul_rsp.prod[52:32];
    assign mv_delta = r_neg ? -$signed({1'b0, mv_mag}) : $signed({1'b0, mv_mag});
    assign mv_base  = (r_phase == PH_MOVE_X) ? r_left : r_top;
    assign mv_edge  = f_sat16(34'(mv_base) + 34'(mv_delta));
    assign fr_mag   = mul_rsp.prod[47:16];
    assign fr_val   = (fr_mag < DEAD_ZONE_Q16) ? 32'sd0
                    : (r_neg ? -$signed(fr_mag) : $signed(fr_mag));

    assign bxe = 34'(r_left) + $signed({22'b0, r_bw});
    assign bye = 34'(r_top) + $signed({22'b0, r_bh});

    assign obs_skip = r_static || !r_collides || (r_bw == '0) || (r_bh == '0)
                   || (in_ew == '0) || (in_eh == '0);
    assign obs_hit  = (r_ovx > 34'sd0) && (r_ovy > 34'sd0);

    abps_mul_ser u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_rsp   (mul_rsp)
    );

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb begin
        n_static   = r_static;
        n_collides = r_collides;
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_STATIC:   n_static   = pwdata[0];
                REG_COLLIDES: n_collides = pwdata[0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_STATIC:   prdata[0] = r_static;
            REG_COLLIDES: prdata[0] = r_collides;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_phase      = r_phase;
        n_mreq       = r_mreq;
        n_mreq.start = 1'b0;
        n_neg        = r_neg;
        n_left       = r_left;
        n_top        = r_top;
        n_bw         = r_bw;
        n_bh         = r_bh;
        n_vh         = r_vh;
        n_vv         = r_vv;
        n_grounded   = r_grounded;
        n_d          = r_d;
        n_ox         = r_ox;
        n_oy         = r_oy;
        n_ow         = r_ow;
        n_oh         = r_oh;
        n_oxe        = r_oxe;
        n_oye        = r_oye;
        n_hix        = r_hix;
        n_hiy        = r_hiy;
        n_lox        = r_lox;
        n_loy        = r_loy;
        n_ovx        = r_ovx;
        n_ovy        = r_ovy;
        n_mvalid     = r_mvalid && !m_axis_tready;
        n_mdata      = r_mdata;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (in_kind)
                        KIND_TICK: begin
                            n_d = in_d;
                            if (r_static) begin
                                n_state = S_FIN;
                            end else begin
                                n_mreq  = '{start: 1'b1, mcand: GRAVITY_Q16, mplier: in_d};
                                n_neg   = 1'b0;
                                n_phase = PH_GRAV;
                                n_state = S_MUL;
                            end
                        end
                        KIND_OBST: begin
                            n_ox    = in_cx;
                            n_oy    = in_cy;
                            n_ow    = in_ew;
                            n_oh    = in_eh;
                            n_state = obs_skip ? S_FIN : S_OBS1;
                        end
                        KIND_FORCE: begin
                            n_vh    = f_sat32(34'(r_vh) + 34'(in_cx));
                            n_vv    = f_sat32(34'(r_vv) + 34'(in_cy));
                            n_state = S_FIN;
                        end
                        KIND_PLACE: begin
                            n_left  = f_sat16(34'(in_cx));
                            n_top   = f_sat16(34'(in_cy));
                            n_bw    = in_ew;
                            n_bh    = in_eh;
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (mul_rsp.done) begin
                    case (r_phase)
                        PH_GRAV: begin
                            n_vv    = vv_grav;
                            n_mreq  = '{start: 1'b1, mcand: f_abs32(r_vh), mplier: r_d};
                            n_neg   = r_vh[31];
                            n_phase = PH_MOVE_X;
                        end
                        PH_MOVE_X: begin
                            n_left  = mv_edge;
                            n_mreq  = '{start: 1'b1, mcand: f_abs32(r_vv), mplier: r_d};
                            n_neg   = r_vv[31];
                            n_phase = PH_MOVE_Y;
                        end
                        PH_MOVE_Y: begin
                            n_top   = mv_edge;
                            n_mreq  = '{start: 1'b1, mcand: f_abs32(r_vh),
                                        mplier: FRICTION_Q16};
                            n_neg   = r_vh[31];
                            n_phase = PH_FRIC;
                        end
                        PH_FRIC: begin
                            n_vh       = fr_val;
                            n_grounded = 1'b0;
                            n_state    = S_FIN;
                        end
                    endcase
                end
            end
            S_OBS1: begin
                n_oxe   = 34'(r_ox) + $signed({22'b0, r_ow});
                n_oye   = 34'(r_oy) + $signed({22'b0, r_oh});
                n_state = S_OBS2;
            end
            S_OBS2: begin
                n_hix   = (bxe < r_oxe) ? bxe : r_oxe;
                n_hiy   = (bye < r_oye) ? bye : r_oye;
                n_lox   = (34'(r_left) > 34'(r_ox)) ? 34'(r_left) : 34'(r_ox);
                n_loy   = (34'(r_top) > 34'(r_oy)) ? 34'(r_top) : 34'(r_oy);
                n_state = S_OBS3;
            end
            S_OBS3: begin
                n_ovx   = r_hix - r_lox;
                n_ovy   = r_hiy - r_loy;
                n_state = S_OBS4;
            end
            S_OBS4: begin
                // Push out along the axis of smaller overlap; a tie goes vertical.
                if (obs_hit) begin
                    if (r_ovx < r_ovy) begin
                        n_left = (34'(r_left) < 34'(r_ox)) ? f_sat16(34'(r_left) - r_ovx)
                                                           : f_sat16(34'(r_left) + r_ovx);
                        n_vh   = '0;
                    end else begin
                        if (34'(r_top) < 34'(r_oy)) begin
                            n_top      = f_sat16(34'(r_top) - r_ovy);
                            n_grounded = 1'b1;
                        end else begin
                            n_top = f_sat16(34'(r_top) + r_ovy);
                        end
                        n_vv = '0;
                    end
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_mvalid || m_axis_tready) begin
                    n_mvalid = 1'b1;
                    n_mdata  = {7'b0, r_grounded, r_vv, r_vh, r_top, r_left};
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_phase    <= PH_GRAV;
            r_mreq     <= '0;
            r_static   <= 1'b0;
            r_collides <= 1'b1;
            r_mvalid   <= 1'b0;
            r_left     <= '0;
            r_top      <= '0;
            r_bw       <= '0;
            r_bh       <= '0;
            r_vh       <= '0;
            r_vv       <= '0;
            r_grounded <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_mreq     <= n_mreq;
            r_static   <= n_static;
            r_collides <= n_collides;
            r_mvalid   <= n_mvalid;
            r_left     <= n_left;
            r_top      <= n_top;
            r_bw       <= n_bw;
            r_bh       <= n_bh;
            r_vh       <= n_vh;
            r_vv       <= n_vv;
            r_grounded <= n_grounded;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d     <= n_d;
        r_neg   <= n_neg;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_ow    <= n_ow;
        r_oh    <= n_oh;
        r_oxe   <= n_oxe;
        r_oye   <= n_oye;
        r_hix   <= n_hix;
        r_hiy   <= n_hiy;
        r_lox   <= n_lox;
        r_loy   <= n_loy;
        r_ovx   <= n_ovx;
        r_ovy   <= n_ovy;
        r_mdata <= n_mdata;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;

endmodule

// ===== src/abps_chk.sv =====
// Port-level checker of the rectangle body block and its binding to the top level.
`include "aabb_body_physics_step_defines.svh"

module abps_chk
    import abps_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    // A result that is not taken stays put.
    `ABPS_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // One item at a time: an accepted beat closes the input until its result is out.
    `ABPS_ASSERT(a_one_in_flight, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "input taken while an item is in flight")

    // A write to the static flag reads back on the next cycle.
    `ABPS_ASSERT(a_cfg_readback, psel && penable && pwrite && pready && !paddr[2] |=> paddr[2] || (prdata[0] == $past(pwdata[0])), "static flag did not take the written value")

    // Reset leaves the block empty and ready for input.
    `ABPS_ASSERT_RST(a_reset_idle, !i_rst_n |=> !m_axis_tvalid && s_axis_tready, "block not idle after reset")

endmodule

bind aabb_body_physics_step abps_chk u_abps_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
);
